FILE: src/yuy2rgb_pkg.sv
`default_nettype none

package yuy2rgb_pkg;

  // BT.601 coefficients in thousandths
  localparam logic [20:0] K_Y     = 21'd1164;
  localparam logic [20:0] K_RV    = 21'd1596;
  localparam logic [20:0] K_BU    = 21'd2018;
  localparam logic [20:0] K_TU    = 21'd391;
  localparam logic [20:0] K_TV    = 21'd813;
  localparam logic [20:0] K_SCALE = 21'd1000;
  localparam logic [20:0] OFF_R   = 21'd222912;
  localparam logic [20:0] OFF_B   = 21'd276928;
  localparam logic [20:0] OFF_T   = 21'd28416;
  localparam logic [20:0] OFF_G   = 21'd109376;

  // floor(n/1000) = (n * ceil(2^28/1000)) >> 28, exact for n below about 493000
  localparam logic [18:0] DIV_RECIP     = 19'd268436;
  localparam int unsigned DIV_SHIFT     = 28;
  localparam logic [19:0] DIV_SAT_LIMIT = 20'd256000;
  localparam logic [7:0]  PIX_MAX       = 8'hFF;

  // after stage 1: luma products and chroma terms
  typedef struct packed {
    logic [18:0] ys0;
    logic [18:0] ys1;
    logic [20:0] r_off;
    logic [20:0] b_off;
    logic [20:0] t_num;
    logic        frame_end;
  } prep_t;

  // after stage 2: red/blue numerators, shared green term
  typedef struct packed {
    logic [18:0] ys0;
    logic [18:0] ys1;
    logic [20:0] r0_num;
    logic [20:0] r1_num;
    logic [20:0] b0_num;
    logic [20:0] b1_num;
    logic [7:0]  t;
    logic        frame_end;
  } mid_t;

  // after stage 3: red/blue done, green numerators
  typedef struct packed {
    logic [7:0]  r0;
    logic [7:0]  r1;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [20:0] g0_num;
    logic [20:0] g1_num;
    logic        frame_end;
  } fin_t;

  typedef struct packed {
    logic [7:0] r0;
    logic [7:0] g0;
    logic [7:0] b0;
    logic [7:0] r1;
    logic [7:0] g1;
    logic [7:0] b1;
    logic       frame_end;
  } pix_t;

  // num is a 21-bit two's complement value; result clamped to 0..255
  function automatic logic [7:0] sat_div(input logic [20:0] num);
    logic [36:0] prod;
    logic [7:0]  res;
    prod = 37'(num[17:0]) * 37'(DIV_RECIP);
    if (num[20]) begin
      res = 8'd0;
    end else if (num[19:0] >= DIV_SAT_LIMIT) begin
      res = PIX_MAX;
    end else begin
      res = prod[DIV_SHIFT +: 8];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: src/yuy2rgb_if.sv
`default_nettype none

interface yuy2rgb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma_first;
  logic [7:0] chroma_blue;
  logic [7:0] luma_second;
  logic [7:0] chroma_red;
  logic       frame_end_in;

  modport source (
    output valid, luma_first, chroma_blue, luma_second, chroma_red, frame_end_in,
    input  ready
  );
  modport sink (
    input  valid, luma_first, chroma_blue, luma_second, chroma_red, frame_end_in,
    output ready
  );
endinterface

interface yuy2rgb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_first;
  logic [7:0] green_first;
  logic [7:0] blue_first;
  logic [7:0] red_second;
  logic [7:0] green_second;
  logic [7:0] blue_second;
  logic       frame_end_out;

  modport source (
    output valid, red_first, green_first, blue_first,
           red_second, green_second, blue_second, frame_end_out,
    input  ready
  );
  modport sink (
    input  valid, red_first, green_first, blue_first,
           red_second, green_second, blue_second, frame_end_out,
    output ready
  );
endinterface

`default_nettype wire

FILE: src/yuy2rgb_prep.sv
`default_nettype none

module yuy2rgb_prep import yuy2rgb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  yuy2rgb_in_if.sink        yuy2_i,
  output logic              mid_valid_o,
  input  logic              mid_ready_i,
  output mid_t              mid_o
);

  logic  s1_v_q, s2_v_q;
  logic  s1_en, s2_en;
  prep_t s1_d, s1_q;
  mid_t  s2_d, s2_q;

  // a stage loads when empty or when the one after it moves
  assign s2_en        = !s2_v_q || mid_ready_i;
  assign s1_en        = !s1_v_q || s2_en;
  assign yuy2_i.ready = s1_en;

  always_comb begin
    s1_d.ys0       = 19'(21'(yuy2_i.luma_first) * K_Y);
    s1_d.ys1       = 19'(21'(yuy2_i.luma_second) * K_Y);
    s1_d.r_off     = 21'(yuy2_i.chroma_red) * K_RV - OFF_R;
    s1_d.b_off     = 21'(yuy2_i.chroma_blue) * K_BU - OFF_B;
    s1_d.t_num     = 21'(yuy2_i.chroma_blue) * K_TU + 21'(yuy2_i.chroma_red) * K_TV - OFF_T;
    s1_d.frame_end = yuy2_i.frame_end_in;
  end

  always_comb begin
    s2_d.ys0       = s1_q.ys0;
    s2_d.ys1       = s1_q.ys1;
    s2_d.r0_num    = 21'(s1_q.ys0) + s1_q.r_off;
    s2_d.r1_num    = 21'(s1_q.ys1) + s1_q.r_off;
    s2_d.b0_num    = 21'(s1_q.ys0) + s1_q.b_off;
    s2_d.b1_num    = 21'(s1_q.ys1) + s1_q.b_off;
    s2_d.t         = sat_div(s1_q.t_num);
    s2_d.frame_end = s1_q.frame_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_v_q <= yuy2_i.valid;
      end
      if (s2_en) begin
        s2_v_q <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && yuy2_i.valid) begin
      s1_q <= s1_d;
    end
    if (s2_en && s1_v_q) begin
      s2_q <= s2_d;
    end
  end

  assign mid_valid_o = s2_v_q;
  assign mid_o       = s2_q;

  a_in_to_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    yuy2_i.valid && yuy2_i.ready |=> s1_v_q)
    else $error("accepted macropixel did not reach stage 1");

  a_t_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && s2_en && s1_q.t_num[20] |=> mid_o.t == 8'd0)
    else $error("negative green chroma term not clamped to zero");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && s2_v_q && !mid_ready_i |=> s1_v_q && !yuy2_i.ready == !s1_en)
    else $error("stage 1 lost an item during a stall");

endmodule

`default_nettype wire

FILE: src/yuy2rgb_finish.sv
`default_nettype none

module yuy2rgb_finish import yuy2rgb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              mid_valid_i,
  output logic              mid_ready_o,
  input  mid_t              mid_i,
  yuy2rgb_out_if.source     rgb_o
);

  logic s3_v_q, s4_v_q;
  logic s3_en, s4_en;
  fin_t s3_d, s3_q;
  pix_t s4_d, s4_q;

  assign s4_en       = !s4_v_q || rgb_o.ready;
  assign s3_en       = !s3_v_q || s4_en;
  assign mid_ready_o = s3_en;

  always_comb begin
    s3_d.r0        = sat_div(mid_i.r0_num);
    s3_d.r1        = sat_div(mid_i.r1_num);
    s3_d.b0        = sat_div(mid_i.b0_num);
    s3_d.b1        = sat_div(mid_i.b1_num);
    s3_d.g0_num    = 21'(mid_i.ys0) - 21'(mid_i.t) * K_SCALE + OFF_G;
    s3_d.g1_num    = 21'(mid_i.ys1) - 21'(mid_i.t) * K_SCALE + OFF_G;
    s3_d.frame_end = mid_i.frame_end;
  end

  always_comb begin
    s4_d.r0        = s3_q.r0;
    s4_d.g0        = sat_div(s3_q.g0_num);
    s4_d.b0        = s3_q.b0;
    s4_d.r1        = s3_q.r1;
    s4_d.g1        = sat_div(s3_q.g1_num);
    s4_d.b1        = s3_q.b1;
    s4_d.frame_end = s3_q.frame_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      if (s3_en) begin
        s3_v_q <= mid_valid_i;
      end
      if (s4_en) begin
        s4_v_q <= s3_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_en && mid_valid_i) begin
      s3_q <= s3_d;
    end
    if (s4_en && s3_v_q) begin
      s4_q <= s4_d;
    end
  end

  assign rgb_o.valid         = s4_v_q;
  assign rgb_o.red_first     = s4_q.r0;
  assign rgb_o.green_first   = s4_q.g0;
  assign rgb_o.blue_first    = s4_q.b0;
  assign rgb_o.red_second    = s4_q.r1;
  assign rgb_o.green_second  = s4_q.g1;
  assign rgb_o.blue_second   = s4_q.b1;
  assign rgb_o.frame_end_out = s4_q.frame_end;

  a_mid_to_s3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_valid_i && mid_ready_o |=> s3_v_q)
    else $error("stage 2 item did not reach stage 3");

  a_g_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_v_q && s4_en && s3_q.g0_num[20] |=> rgb_o.green_first == 8'd0)
    else $error("negative green sum not clamped to zero");

  a_g_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_v_q && s4_en && !s3_q.g1_num[20] && (s3_q.g1_num[19:0] >= DIV_SAT_LIMIT)
    |=> rgb_o.green_second == PIX_MAX)
    else $error("large green sum not clamped to full scale");

endmodule

`default_nettype wire

FILE: src/yuy2_to_rgb24_convert_unit.sv
// YUY2 macropixel to two RGB24 pixels, BT.601 studio range.
// 4 register stages: s1 and s2 in yuy2rgb_prep, s3 and s4 in yuy2rgb_finish.
// Throughput: one macropixel per cycle while not stalled; each stage loads when empty or draining,
// so a stall at the output backs up stage by stage without dropping items.
// Reset (rst_ni, async, active low) clears the stage valid bits only.
`default_nettype none

module yuy2_to_rgb24_convert_unit import yuy2rgb_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  yuy2rgb_in_if.sink    yuy2_i,
  yuy2rgb_out_if.source rgb_o
);

  logic mid_valid;
  logic mid_ready;
  mid_t mid;

  yuy2rgb_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .yuy2_i      (yuy2_i),
    .mid_valid_o (mid_valid),
    .mid_ready_i (mid_ready),
    .mid_o       (mid)
  );

  yuy2rgb_finish u_finish (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_valid_i (mid_valid),
    .mid_ready_o (mid_ready),
    .mid_i       (mid),
    .rgb_o       (rgb_o)
  );

endmodule

`default_nettype wire

FILE: sim/yuy2_to_rgb24_convert_unit_tb.sv
`default_nettype none

module yuy2_to_rgb24_convert_unit_tb import yuy2rgb_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // BT.601 studio-range terms, thousandths
  localparam int Y_GAIN   = 1164;
  localparam int RV_GAIN  = 1596;
  localparam int BU_GAIN  = 2018;
  localparam int TU_GAIN  = 391;
  localparam int TV_GAIN  = 813;
  localparam int T_WEIGHT = 1000;
  localparam int R_BIAS   = 222912;
  localparam int B_BIAS   = 276928;
  localparam int T_BIAS   = 28416;
  localparam int G_BIAS   = 109376;
  localparam int UNIT     = 1000;
  localparam int CHAN_MAX = 255;

  localparam int RANDOM_PIXELS = 1050;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_AT       = 300;
  localparam int HOLD_CYCLES   = 120;

  typedef struct {
    logic [7:0] y0;
    logic [7:0] u;
    logic [7:0] y1;
    logic [7:0] v;
    logic       frame_end;
    bit         drain_first;
  } macropixel_t;

  logic clk_i;
  logic rst_ni;

  yuy2rgb_in_if  yuy2_bus ();
  yuy2rgb_out_if rgb_bus ();

  yuy2_to_rgb24_convert_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .yuy2_i (yuy2_bus),
    .rgb_o  (rgb_bus)
  );

  macropixel_t pixel_queue[$];
  pix_t        rgb_expected_q[$];

  int err_count;
  int taken_count;
  int rgb_checked;
  int frame_ends_seen;
  int clamp_lo_seen;
  int clamp_hi_seen;
  int cycle_count;
  bit in_took;

  int burst_left;
  int gap_left;
  int hold_left;
  bit hold_done;
  int ready_mode;
  int ready_win_left;
  int ready_phase;
  logic [7:0] ready_mask;

  function automatic logic [7:0] scale_clamp(input int num);
    int q;
    if (num < 0) begin
      return 8'd0;
    end
    q = num / UNIT;
    if (q > CHAN_MAX) begin
      return 8'(CHAN_MAX);
    end
    return q[7:0];
  endfunction

  function automatic pix_t predict_rgb(input macropixel_t m);
    pix_t p;
    int   t;
    t = int'(scale_clamp(TU_GAIN * int'(m.u) + TV_GAIN * int'(m.v) - T_BIAS));
    p.r0 = scale_clamp(Y_GAIN * int'(m.y0) + RV_GAIN * int'(m.v) - R_BIAS);
    p.g0 = scale_clamp(Y_GAIN * int'(m.y0) - T_WEIGHT * t + G_BIAS);
    p.b0 = scale_clamp(Y_GAIN * int'(m.y0) + BU_GAIN * int'(m.u) - B_BIAS);
    p.r1 = scale_clamp(Y_GAIN * int'(m.y1) + RV_GAIN * int'(m.v) - R_BIAS);
    p.g1 = scale_clamp(Y_GAIN * int'(m.y1) - T_WEIGHT * t + G_BIAS);
    p.b1 = scale_clamp(Y_GAIN * int'(m.y1) + BU_GAIN * int'(m.u) - B_BIAS);
    p.frame_end = m.frame_end;
    return p;
  endfunction

  task automatic add_pixel(input logic [7:0] y0, input logic [7:0] u,
                           input logic [7:0] y1, input logic [7:0] v,
                           input logic fe, input bit drain);
    macropixel_t m;
    m.y0 = y0;
    m.u = u;
    m.y1 = y1;
    m.v = v;
    m.frame_end = fe;
    m.drain_first = drain;
    pixel_queue.push_back(m);
  endtask

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch: result %0d %s got %0d want %0d", rgb_checked, field, got, want);
    err_count++;
  endtask

  function automatic logic [7:0] pick_sample(input bit chroma);
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 14) begin
      return 8'($urandom_range(0, 255));
    end else if (sel < 17) begin
      return chroma ? 8'($urandom_range(16, 240)) : 8'($urandom_range(16, 235));
    end
    case ($urandom_range(0, 6))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd16;
      3: return 8'd128;
      4: return 8'd235;
      5: return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // input side: bursts with random gaps, optional wait for the pipe to empty
  always @(negedge clk_i) begin
    if (rst_ni && (!yuy2_bus.valid || in_took)) begin
      if (pixel_queue.size() == 0) begin
        yuy2_bus.valid <= 1'b0;
      end else if (gap_left > 0) begin
        yuy2_bus.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pixel_queue[0].drain_first && rgb_expected_q.size() != 0) begin
        yuy2_bus.valid <= 1'b0;
      end else begin
        macropixel_t m;
        m = pixel_queue.pop_front();
        yuy2_bus.valid        <= 1'b1;
        yuy2_bus.luma_first   <= m.y0;
        yuy2_bus.chroma_blue  <= m.u;
        yuy2_bus.luma_second  <= m.y1;
        yuy2_bus.chroma_red   <= m.v;
        yuy2_bus.frame_end_in <= m.frame_end;
        if (burst_left <= 1) begin
          if ($urandom_range(0, 4) == 0) begin
            burst_left <= $urandom_range(40, 80);
            gap_left <= 0;
          end else begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // long output hold-off, once, after enough transfers have gone in
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && taken_count >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // output side: stall pattern changes every window
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (ready_win_left == 0) begin
        ready_mode <= $urandom_range(0, 3);
        ready_mask <= 8'($urandom_range(1, 255));
        ready_win_left <= $urandom_range(16, 96);
      end else begin
        ready_win_left <= ready_win_left - 1;
      end
      ready_phase <= (ready_phase + 1) % 8;
      if (hold_left != 0) begin
        rgb_bus.ready <= 1'b0;
      end else begin
        case (ready_mode)
          0: rgb_bus.ready <= 1'b1;
          1: rgb_bus.ready <= 1'($urandom_range(0, 1));
          2: rgb_bus.ready <= ($urandom_range(0, 3) == 0);
          default: rgb_bus.ready <= ready_mask[ready_phase];
        endcase
      end
    end
  end

  // check result transfers, then record input transfers
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rgb_bus.valid && rgb_bus.ready) begin
        if (rgb_expected_q.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          pix_t want;
          want = rgb_expected_q.pop_front();
          if (rgb_bus.red_first !== want.r0)
            report_mismatch("red_first", rgb_bus.red_first, want.r0);
          if (rgb_bus.green_first !== want.g0)
            report_mismatch("green_first", rgb_bus.green_first, want.g0);
          if (rgb_bus.blue_first !== want.b0)
            report_mismatch("blue_first", rgb_bus.blue_first, want.b0);
          if (rgb_bus.red_second !== want.r1)
            report_mismatch("red_second", rgb_bus.red_second, want.r1);
          if (rgb_bus.green_second !== want.g1)
            report_mismatch("green_second", rgb_bus.green_second, want.g1);
          if (rgb_bus.blue_second !== want.b1)
            report_mismatch("blue_second", rgb_bus.blue_second, want.b1);
          if (rgb_bus.frame_end_out !== want.frame_end)
            report_mismatch("frame_end_out", rgb_bus.frame_end_out, want.frame_end);
          if (want.frame_end)
            frame_ends_seen++;
          if (want.r0 == 0 || want.g0 == 0 || want.b0 == 0 ||
              want.r1 == 0 || want.g1 == 0 || want.b1 == 0)
            clamp_lo_seen++;
          if (want.r0 == 255 || want.g0 == 255 || want.b0 == 255 ||
              want.r1 == 255 || want.g1 == 255 || want.b1 == 255)
            clamp_hi_seen++;
        end
        rgb_checked++;
      end
      in_took <= yuy2_bus.valid && yuy2_bus.ready;
      if (yuy2_bus.valid && yuy2_bus.ready) begin
        macropixel_t m;
        m.y0 = yuy2_bus.luma_first;
        m.u = yuy2_bus.chroma_blue;
        m.y1 = yuy2_bus.luma_second;
        m.v = yuy2_bus.chroma_red;
        m.frame_end = yuy2_bus.frame_end_in;
        m.drain_first = 1'b0;
        rgb_expected_q.push_back(predict_rgb(m));
        taken_count <= taken_count + 1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               rgb_expected_q.size());
      $display("yuy2_to_rgb24_convert_unit_tb: errors");
      $finish;
    end
  end

  initial begin
    int n;
    int frame_len;
    logic fe;
    rst_ni = 1'b0;
    yuy2_bus.valid = 1'b0;
    yuy2_bus.luma_first = '0;
    yuy2_bus.chroma_blue = '0;
    yuy2_bus.luma_second = '0;
    yuy2_bus.chroma_red = '0;
    yuy2_bus.frame_end_in = 1'b0;
    rgb_bus.ready = 1'b0;
    err_count = 0;
    taken_count = 0;
    rgb_checked = 0;
    frame_ends_seen = 0;
    clamp_lo_seen = 0;
    clamp_hi_seen = 0;
    cycle_count = 0;
    in_took = 1'b0;
    burst_left = 25;
    gap_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    ready_mode = 0;
    ready_win_left = 30;
    ready_phase = 0;
    ready_mask = 8'hFF;

    // corners: black/white, chroma extremes, t clamped low and high, bit patterns
    add_pixel(8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 1'b0);
    add_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0);
    add_pixel(8'd16,  8'd128, 8'd235, 8'd128, 1'b0, 1'b0);
    add_pixel(8'd0,   8'd0,   8'd255, 8'd0,   1'b0, 1'b0);
    add_pixel(8'd255, 8'd255, 8'd0,   8'd255, 1'b0, 1'b0);
    add_pixel(8'd0,   8'd255, 8'd255, 8'd0,   1'b1, 1'b0);
    add_pixel(8'd255, 8'd0,   8'd0,   8'd255, 1'b0, 1'b0);
    add_pixel(8'h55,  8'hAA,  8'h55,  8'hAA,  1'b0, 1'b0);
    add_pixel(8'hAA,  8'h55,  8'hAA,  8'h55,  1'b1, 1'b0);
    add_pixel(8'd16,  8'd16,  8'd235, 8'd240, 1'b0, 1'b0);
    add_pixel(8'd235, 8'd240, 8'd16,  8'd16,  1'b0, 1'b0);
    add_pixel(8'd128, 8'd128, 8'd128, 8'd128, 1'b1, 1'b0);
    add_pixel(8'd1,   8'd254, 8'd254, 8'd1,   1'b0, 1'b0);
    add_pixel(8'd81,  8'd90,  8'd145, 8'd240, 1'b0, 1'b0);
    add_pixel(8'd41,  8'd240, 8'd210, 8'd110, 1'b0, 1'b0);
    add_pixel(8'd191, 8'd128, 8'd64,  8'd128, 1'b1, 1'b0);
    add_pixel(8'd0,   8'd128, 8'd255, 8'd128, 1'b0, 1'b0);
    add_pixel(8'd255, 8'd16,  8'd0,   8'd16,  1'b1, 1'b0);

    // frames of random length; occasionally a stray or missing frame end
    n = 0;
    while (n < RANDOM_PIXELS) begin
      frame_len = $urandom_range(1, 40);
      for (int k = 0; k < frame_len && n < RANDOM_PIXELS; k++) begin
        fe = (k == frame_len - 1);
        if ($urandom_range(0, 19) == 0)
          fe = ~fe;
        add_pixel(pick_sample(1'b0), pick_sample(1'b1), pick_sample(1'b0),
                  pick_sample(1'b1), fe, (n == 250 || n == 600 || n == 900));
        n++;
      end
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pixel_queue.size() != 0 || yuy2_bus.valid) @(posedge clk_i);
    while (rgb_expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("%0d macropixels in, %0d RGB pairs checked, %0d frame ends", taken_count,
             rgb_checked, frame_ends_seen);
    $display("pairs with a channel clamped to 0: %0d, to 255: %0d; %0d mismatches",
             clamp_lo_seen, clamp_hi_seen, err_count);
    if (err_count == 0) begin
      $display("yuy2_to_rgb24_convert_unit_tb: clean");
    end else begin
      $display("yuy2_to_rgb24_convert_unit_tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
src/yuy2rgb_pkg.sv
src/yuy2rgb_if.sv
src/yuy2rgb_prep.sv
src/yuy2rgb_finish.sv
src/yuy2_to_rgb24_convert_unit.sv
sim/yuy2_to_rgb24_convert_unit_tb.sv
